FILE: rtl/uvs_pkg.sv
`timescale 1ns / 1ps
// Package of the UV sphere point generator: types, constants and arithmetic helpers.
package uvs_pkg;

    localparam int MAX_SLICES_DEF = 64;
    localparam int NUM_STAGES     = 14;

    // Configuration register indexes.
    localparam logic [1:0] REG_COLUMNS      = 2'd0;
    localparam logic [1:0] REG_RINGS        = 2'd1;
    localparam logic [1:0] REG_TEXTURE_MODE = 2'd2;

    // Odd Taylor coefficients of sin(pi/2*x) in Q30, highest order first.
    localparam logic [31:0] K9 = 32'd172272;
    localparam logic [31:0] HORNER_K [4] = '{32'd5026995, 32'd85569306,
                                              32'd693598668, 32'd1686629713};

    localparam logic [23:0] QUARTER_TURN = 24'h400000;

    typedef struct packed {
        logic [6:0]  rem;
        logic [31:0] word;
    } div_t;

    typedef struct packed {
        logic [6:0]         ring;
        logic [5:0]         col;
        logic [12:0]        vertex;
        logic               qv;
        logic [12:0]        ca;
        logic [12:0]        cb;
        logic [12:0]        cc;
        logic [12:0]        cd;
        div_t [3:0]         dv;
        logic [3:0]         sneg;
        logic [3:0][30:0]   xs;
        logic [3:0][30:0]   x2;
        logic [3:0][31:0]   p;
        logic [3:0][15:0]   sv;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [15:0]        px;
        logic [15:0]        py;
        logic [15:0]        pz;
    } pipe_t;

    // Eight steps of restoring division; the quotient shifts into the word.
    function automatic div_t div8(div_t s, logic [6:0] d);
        div_t       r;
        logic [7:0] t;
        r = s;
        for (int i = 0; i < 8; i++) begin
            t = {r.rem, r.word[31]};
            r.word = {r.word[30:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t = t - {1'b0, d};
                r.word[0] = 1'b1;
            end
            r.rem = t[6:0];
        end
        return r;
    endfunction

    // Rounds a Q30 quarter sine to a signed Q1.14 value.
    function automatic logic [15:0] sin_round(logic [31:0] s, logic neg);
        logic [32:0] t;
        logic [15:0] m;
        t = ({1'b0, s} + 33'd32768) >> 16;
        m = (t > 33'd16384) ? 16'd16384 : t[15:0];
        return neg ? (16'd0 - m) : m;
    endfunction

    // Q1.14 product rounded half away from zero on the magnitude.
    function automatic logic [15:0] mul_q14(logic signed [15:0] a, logic signed [15:0] b);
        logic [15:0] ma;
        logic [15:0] mb;
        logic [31:0] pr;
        logic [15:0] r;
        ma = a[15] ? (16'd0 - a) : a;
        mb = b[15] ? (16'd0 - b) : b;
        pr = ((32'(ma) * 32'(mb)) + 32'd8192) >> 14;
        r  = pr[15:0];
        return (a[15] != b[15]) ? (16'd0 - r) : r;
    endfunction

endpackage

FILE: rtl/uv_sphere_point_generator_top.sv
`timescale 1ns / 1ps
// UV sphere point generator: 14-stage pipeline from grid point to vertex word.
// Throughput is one word per cycle while out_stall is low; each stage holds one
// word and moves on when the stage after it is free, so bubbles close up while the
// output is stalled. Reset (rst_n low, asynchronous) empties the pipeline and sets
// columns and rings to 16 and texture mode on.
module uv_sphere_point_generator_top #(
    parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [6:0]         ring_index,
    input  logic [5:0]         column_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [12:0]        vertex_number,
    output logic               quad_valid,
    output logic [12:0]        corner_a,
    output logic [12:0]        corner_b,
    output logic [12:0]        corner_c,
    output logic [12:0]        corner_d
);

    localparam int NST = uvs_pkg::NUM_STAGES;

    logic [6:0] columns_reg;
    logic [6:0] rings_reg;
    logic       texture_mode_reg;
    logic [6:0] cols_eff;
    logic [6:0] rings_eff;

    uvs_pkg::pipe_t stage_reg  [NST];
    uvs_pkg::pipe_t stage_next [NST];
    logic [NST-1:0] valid_reg;
    logic [NST:0]   ready;

    // Config regs: user must change them only while pipeline is empty; unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg      <= 7'd16;
            rings_reg        <= 7'd16;
            texture_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uvs_pkg::REG_COLUMNS:      columns_reg      <= cfg_data;
                uvs_pkg::REG_RINGS:        rings_reg        <= cfg_data;
                uvs_pkg::REG_TEXTURE_MODE: texture_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A slice count of zero acts as one and a count above the limit as the limit.
    assign cols_eff  = (columns_reg == 7'd0) ? 7'd1 :
                       ({25'd0, columns_reg} > MAX_SLICES) ? 7'(MAX_SLICES) : columns_reg;
    assign rings_eff = (rings_reg == 7'd0) ? 7'd1 :
                       ({25'd0, rings_reg} > MAX_SLICES) ? 7'(MAX_SLICES) : rings_reg;

    // Ready chain: a stage takes a new word when it is empty or its word leaves.
    always_comb
    begin
        ready[NST] = !out_stall;
        for (int k = NST - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end
    assign in_stall = !ready[0];

    always_comb
    begin
        logic [7:0]  t;
        logic [6:0]  rem;
        logic [13:0] base;
        logic [13:0] av;
        logic [13:0] cv;
        logic [6:0]  cnext;
        logic [23:0] ang;
        logic [22:0] f;
        logic [63:0] prod;
        uvs_pkg::pipe_t s;

        // Stage 0: clamp the ring and reduce the column modulo columns.
        s = '0;
        s.ring = (ring_index > rings_eff) ? rings_eff : ring_index;
        rem = 7'd0;
        for (int i = 5; i >= 0; i--)
        begin
            t = {rem, column_index[i]};
            if (t >= {1'b0, cols_eff})
            begin
                t = t - {1'b0, cols_eff};
            end
            rem = t[6:0];
        end
        s.col = rem[5:0];
        stage_next[0] = s;

        // Stages 1 to 4: four 32-step dividers, eight steps per stage.
        // Stage 1 also loads the numerators and forms the vertex indices.
        for (int k = 1; k <= 4; k++)
        begin
            s = stage_reg[k-1];
            if (k == 1)
            begin
                s.dv[0] = '{rem: 7'd0,
                            word: {2'd0, s.ring, 23'd0} + 32'(rings_eff[6:1])};
                s.dv[1] = '{rem: 7'd0,
                            word: {2'd0, s.col, 24'd0} + 32'(cols_eff[6:1])};
                s.dv[2] = '{rem: 7'd0,
                            word: {10'd0, s.col, 16'd0} + 32'(cols_eff[6:1])};
                s.dv[3] = '{rem: 7'd0,
                            word: {9'd0, s.ring, 16'd0} + 32'(rings_eff[6:1])};
                base  = 14'(s.ring) * 14'(cols_eff);
                av    = base + 14'(s.col);
                cnext = ({1'b0, s.col} + 7'd1 == cols_eff) ? 7'd0 : {1'b0, s.col} + 7'd1;
                cv    = base + 14'(cnext);
                s.vertex = av[12:0];
                s.qv     = (s.ring < rings_eff);
                if (s.qv)
                begin
                    s.ca = av[12:0];
                    s.cb = av[12:0] + 13'(cols_eff);
                    s.cc = cv[12:0];
                    s.cd = cv[12:0] + 13'(cols_eff);
                end
                else
                begin
                    s.ca = 13'd0;
                    s.cb = 13'd0;
                    s.cc = 13'd0;
                    s.cd = 13'd0;
                end
            end
            s.dv[0] = uvs_pkg::div8(s.dv[0], rings_eff);
            s.dv[1] = uvs_pkg::div8(s.dv[1], cols_eff);
            s.dv[2] = uvs_pkg::div8(s.dv[2], cols_eff);
            s.dv[3] = uvs_pkg::div8(s.dv[3], rings_eff);
            stage_next[k] = s;
        end

        // Stage 5: fold each angle into its quadrant; lanes are sin phi, cos phi,
        // sin theta and cos theta. Texture coordinates are settled here.
        s = stage_reg[4];
        for (int j = 0; j < 4; j++)
        begin
            ang = (j < 2) ? s.dv[0].word[23:0] : s.dv[1].word[23:0];
            if (j == 1 || j == 3)
            begin
                ang = ang + uvs_pkg::QUARTER_TURN;
            end
            f = {1'b0, ang[21:0]};
            if (ang[22])
            begin
                f = 23'h400000 - f;
            end
            s.xs[j]   = {f, 8'd0};
            s.sneg[j] = ang[23];
        end
        s.u = texture_mode_reg ? s.dv[2].word[16:0] : 17'd0;
        s.v = texture_mode_reg ? s.dv[3].word[16:0] : 17'd0;
        stage_next[5] = s;

        // Stage 6: square of the argument.
        s = stage_reg[5];
        for (int j = 0; j < 4; j++)
        begin
            prod    = 64'(s.xs[j]) * 64'(s.xs[j]);
            s.x2[j] = prod[60:30];
            s.p[j]  = uvs_pkg::K9;
        end
        stage_next[6] = s;

        // Stages 7 to 10: one Horner step each.
        for (int k = 7; k <= 10; k++)
        begin
            s = stage_reg[k-1];
            for (int j = 0; j < 4; j++)
            begin
                prod   = 64'(s.x2[j]) * 64'(s.p[j]);
                s.p[j] = uvs_pkg::HORNER_K[k-7] - prod[61:30];
            end
            stage_next[k] = s;
        end

        // Stage 11: final multiply by the argument.
        s = stage_reg[10];
        for (int j = 0; j < 4; j++)
        begin
            prod   = 64'(s.xs[j]) * 64'(s.p[j]);
            s.p[j] = prod[61:30];
        end
        stage_next[11] = s;

        // Stage 12: round to Q1.14 and apply the quadrant sign.
        s = stage_reg[11];
        for (int j = 0; j < 4; j++)
        begin
            s.sv[j] = uvs_pkg::sin_round(s.p[j], s.sneg[j]);
        end
        stage_next[12] = s;

        // Stage 13: position products; this stage is the output register.
        s = stage_reg[12];
        s.px = uvs_pkg::mul_q14(s.sv[0], s.sv[3]);
        s.py = uvs_pkg::mul_q14(s.sv[0], s.sv[2]);
        s.pz = s.sv[1];
        stage_next[13] = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (ready[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid     = valid_reg[NST-1];
    assign pos_x         = stage_reg[NST-1].px;
    assign pos_y         = stage_reg[NST-1].py;
    assign pos_z         = stage_reg[NST-1].pz;
    assign tex_u         = stage_reg[NST-1].u;
    assign tex_v         = stage_reg[NST-1].v;
    assign vertex_number = stage_reg[NST-1].vertex;
    assign quad_valid    = stage_reg[NST-1].qv;
    assign corner_a      = stage_reg[NST-1].ca;
    assign corner_b      = stage_reg[NST-1].cb;
    assign corner_c      = stage_reg[NST-1].cc;
    assign corner_d      = stage_reg[NST-1].cd;

endmodule
